[src/xcfd_pkg.sv]
// xcfd_pkg: shared types and constants of the xor checked frame deframer
// no dependencies; used by the parser, the result queue and the top level
`default_nettype none

package xcfd_pkg;

  // framing bytes
  localparam logic [7:0] HDR_BYTE  = 8'h24;
  localparam logic [7:0] MARK_BYTE = 8'h23;
  localparam logic [7:0] CR_BYTE   = 8'h0D;
  localparam logic [7:0] LF_BYTE   = 8'h0A;

  localparam logic [15:0] MAX_LEN_RESET = 16'd128;

  // result queue geometry
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef enum logic [2:0] {
    ST_GOOD    = 3'd0,
    ST_NOMARK  = 3'd1,
    ST_CSUM    = 3'd2,
    ST_TRAILER = 3'd3,
    ST_TOOLONG = 3'd4,
    ST_TRUNC   = 3'd5
  } status_e;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_REPORT  = 1'b1
  } kind_e;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [15:0] byte_index;
    logic [15:0] command;
    logic [15:0] payload_length;
    logic [2:0]  status;
  } result_t;

  // up to two results produced by one input byte
  typedef struct packed {
    logic [1:0] count;
    result_t    res0;
    result_t    res1;
  } push_t;

endpackage

`default_nettype wire

[src/xcfd_if.sv]
// xcfd_byte_if and xcfd_result_if: valid/ready channels of the deframer
// depends on nothing but the port widths of the block
`default_nettype none

interface xcfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       buffer_end;

  modport source (output valid, output rx_byte, output buffer_end, input ready);
  modport sink   (input valid, input rx_byte, input buffer_end, output ready);
endinterface

interface xcfd_result_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  data_byte;
  logic [15:0] byte_index;
  logic [15:0] command;
  logic [15:0] payload_length;
  logic [2:0]  status;

  modport source (output valid, output kind, output data_byte, output byte_index,
                  output command, output payload_length, output status, input ready);
  modport sink   (input valid, input kind, input data_byte, input byte_index,
                  input command, input payload_length, input status, output ready);
endinterface

`default_nettype wire

[src/xor_checked_frame_deframer.sv]
// xor_checked_frame_deframer: top level, length register, parser and result queue
// depends on xcfd_pkg, xcfd_if, xcfd_parser and xcfd_result_fifo
//
// Usage:
//   byte_i carries the received stream, one rx_byte per transfer, with
//   buffer_end set on the last byte of a receive buffer. result_o carries
//   payload bytes (kind 0) as they arrive and one report (kind 1) at the end
//   of every frame that got past its header, with command, length and status.
//   cfg_we_i/cfg_wdata_i write the longest accepted payload length; write it
//   only while the block is idle.
// Results: each result is queued with its byte transfer, behind older results.
// Throughput: one byte per cycle while byte_i.ready is high. A byte that causes
//   two results (a payload byte with buffer_end set) pushes both; the queue
//   holds four entries and byte_i.ready drops while it holds more than two.
// Stall: when the receiver holds result_o.ready low, results wait in the
//   queue in order and byte_i keeps taking bytes until the queue is nearly full.
// Reset: hunting for a header, maximum length 128, queue empty.
`default_nettype none

module xor_checked_frame_deframer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  xcfd_byte_if.sink        byte_i,
  xcfd_result_if.source    result_o
);
  import xcfd_pkg::*;

  logic [15:0] max_len_q;
  logic        fire;
  logic        space;
  push_t       push;
  result_t     head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MAX_LEN_RESET;
    end else if (cfg_we_i) begin
      max_len_q <= cfg_wdata_i;
    end
  end

  assign byte_i.ready = space;
  assign fire         = byte_i.valid & space;

  xcfd_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .rx_byte_i    (byte_i.rx_byte),
    .buffer_end_i (byte_i.buffer_end),
    .max_len_i    (max_len_q),
    .push_o       (push)
  );

  xcfd_result_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .space_o (space),
    .valid_o (result_o.valid),
    .ready_i (result_o.ready),
    .data_o  (head)
  );

  assign result_o.kind           = head.kind;
  assign result_o.data_byte      = head.data_byte;
  assign result_o.byte_index     = head.byte_index;
  assign result_o.command        = head.command;
  assign result_o.payload_length = head.payload_length;
  assign result_o.status         = head.status;

endmodule

`default_nettype wire

[src/xcfd_parser.sv]
// xcfd_parser: frame state machine, one input byte per cycle while fire_i is set, up to two results
// depends on xcfd_pkg
`default_nettype none

module xcfd_parser (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            fire_i,
  input  wire logic [7:0]      rx_byte_i,
  input  wire logic            buffer_end_i,
  input  wire logic [15:0]     max_len_i,
  output xcfd_pkg::push_t      push_o
);
  import xcfd_pkg::*;

  typedef enum logic [3:0] {
    PH_HUNT0, PH_HUNT1, PH_CMD_HI, PH_CMD_LO, PH_LEN_LO, PH_LEN_HI,
    PH_PAYLOAD, PH_MARK, PH_CSUM, PH_CR, PH_LF
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [15:0] count_q, count_d;
  logic [15:0] len_q, len_d;
  logic [15:0] cmd_q, cmd_d;
  logic [7:0]  csum_q, csum_d;

  function automatic result_t mk_result(logic kind, logic [7:0] data, logic [15:0] idx,
                                        logic [15:0] cmd, logic [15:0] len,
                                        logic [2:0] st);
    result_t r;
    r.kind           = kind;
    r.data_byte      = data;
    r.byte_index     = idx;
    r.command        = cmd;
    r.payload_length = len;
    r.status         = st;
    return r;
  endfunction

  always_comb begin
    result_t    r;
    logic       rep;
    logic [2:0] rep_st;
    phase_d = phase_q;
    count_d = count_q;
    len_d   = len_q;
    cmd_d   = cmd_q;
    csum_d  = csum_q;
    push_o  = '0;
    rep     = 1'b0;
    rep_st  = ST_GOOD;
    r       = '0;

    if (fire_i) begin
      case (phase_q)
        PH_HUNT0: begin
          if (rx_byte_i == HDR_BYTE) phase_d = PH_HUNT1;
        end
        PH_HUNT1: begin
          if (rx_byte_i == HDR_BYTE) begin
            phase_d = PH_CMD_HI;
            count_d = '0;
            len_d   = '0;
            cmd_d   = '0;
            csum_d  = '0;
          end else begin
            phase_d = PH_HUNT0;
          end
        end
        PH_CMD_HI: begin
          cmd_d   = {rx_byte_i, 8'h00};
          csum_d  = rx_byte_i;
          phase_d = PH_CMD_LO;
        end
        PH_CMD_LO: begin
          cmd_d   = {cmd_q[15:8], rx_byte_i};
          csum_d  = csum_q ^ rx_byte_i;
          phase_d = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          len_d   = {8'h00, rx_byte_i};
          csum_d  = csum_q ^ rx_byte_i;
          phase_d = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          len_d   = {rx_byte_i, len_q[7:0]};
          csum_d  = csum_q ^ rx_byte_i;
          count_d = '0;
          if (len_d > max_len_i) begin
            rep    = 1'b1;
            rep_st = ST_TOOLONG;
          end else if (len_d == 16'd0) begin
            phase_d = PH_MARK;
          end else begin
            phase_d = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          push_o.res0  = mk_result(KIND_PAYLOAD, rx_byte_i, count_q, cmd_q, len_q, ST_GOOD);
          push_o.count = 2'd1;
          csum_d       = csum_q ^ rx_byte_i;
          count_d      = count_q + 16'd1;
          if (count_d >= len_q) phase_d = PH_MARK;
        end
        PH_MARK: begin
          if (rx_byte_i != MARK_BYTE) begin
            rep    = 1'b1;
            rep_st = ST_NOMARK;
          end else begin
            phase_d = PH_CSUM;
          end
        end
        PH_CSUM: begin
          if (rx_byte_i != csum_q) begin
            rep    = 1'b1;
            rep_st = ST_CSUM;
          end else begin
            phase_d = PH_CR;
          end
        end
        PH_CR: begin
          if (rx_byte_i != CR_BYTE) begin
            rep    = 1'b1;
            rep_st = ST_TRAILER;
          end else begin
            phase_d = PH_LF;
          end
        end
        PH_LF: begin
          rep    = 1'b1;
          rep_st = (rx_byte_i == LF_BYTE) ? ST_GOOD : ST_TRAILER;
        end
        default: begin
          phase_d = PH_HUNT0;
        end
      endcase

      if (rep) begin
        push_o.res0  = mk_result(KIND_REPORT, 8'h00, count_d, cmd_d, len_d, rep_st);
        push_o.count = 2'd1;
        phase_d      = PH_HUNT0;
      end

      // buffer end cuts off any frame that got past its header
      if (buffer_end_i) begin
        if (phase_d != PH_HUNT0 && phase_d != PH_HUNT1) begin
          r = mk_result(KIND_REPORT, 8'h00, count_d, cmd_d, len_d, ST_TRUNC);
          if (push_o.count == 2'd0) begin
            push_o.res0  = r;
            push_o.count = 2'd1;
          end else begin
            push_o.res1  = r;
            push_o.count = 2'd2;
          end
        end
        phase_d = PH_HUNT0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT0;
      count_q <= '0;
      len_q   <= '0;
      cmd_q   <= '0;
      csum_q  <= '0;
    end else begin
      phase_q <= phase_d;
      count_q <= count_d;
      len_q   <= len_d;
      cmd_q   <= cmd_d;
      csum_q  <= csum_d;
    end
  end

endmodule

`default_nettype wire

[src/xcfd_result_fifo.sv]
// xcfd_result_fifo: small result queue, up to two writes and one read per cycle
// depends on xcfd_pkg
`default_nettype none

module xcfd_result_fifo (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire xcfd_pkg::push_t   push_i,
  output logic                   space_o,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output xcfd_pkg::result_t      data_o
);
  import xcfd_pkg::*;

  localparam int unsigned CW = FIFO_AW + 1;

  result_t             mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]       count_q, count_d;
  logic                pop;

  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign pop     = valid_o & ready_i;
  // room for the two results one byte can cause
  assign space_o = (count_q <= CW'(FIFO_DEPTH - 2));
  assign count_d = count_q + CW'(push_i.count) - CW'(pop);

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) mem_q[wr_ptr_q] <= push_i.res0;
    if (push_i.count == 2'd2) mem_q[wr_ptr_q + FIFO_AW'(1)] <= push_i.res1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + FIFO_AW'(push_i.count);
      rd_ptr_q <= rd_ptr_q + FIFO_AW'(pop);
      count_q  <= count_d;
    end
  end

endmodule

`default_nettype wire
